// ===== rtl/sai_pkg.sv =====
package sai_pkg;

    // datapath widths of the shared cordic unit
    localparam int XW = 40;
    localparam int ZW = 34;

    // default parameter values
    localparam int DEF_MAX_ARC_POINTS = 100001;
    localparam int DEF_CORDIC_ITERS   = 24;

    // cordic start gain, 0.60725293 in q2.30
    localparam logic [XW-1:0] CORDIC_GAIN_INV = XW'(652032874);
    // 2^32 / (2*pi), rounded
    localparam logic [29:0]   TURN_PER_RAD    = 30'd683565276;
    localparam logic [31:0]   HALF_TURN       = 32'h8000_0000;

    typedef struct packed {
        logic start;
        logic vec;
    } cordic_cmd_t;

    function automatic logic [31:0] atan_bau(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/sai_cordic.sv =====
module sai_cordic #(
    parameter int CORDIC_ITERS = sai_pkg::DEF_CORDIC_ITERS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sai_pkg::cordic_cmd_t              cmd,
    input  logic signed [sai_pkg::XW-1:0]     x_in,
    input  logic signed [sai_pkg::XW-1:0]     y_in,
    input  logic signed [sai_pkg::ZW-1:0]     z_in,
    output logic                              done,
    output logic signed [sai_pkg::XW-1:0]     x_out,
    output logic signed [sai_pkg::XW-1:0]     y_out,
    output logic signed [sai_pkg::ZW-1:0]     z_out
);

    logic signed [sai_pkg::XW-1:0] x_reg, y_reg, xs, ys;
    logic signed [sai_pkg::ZW-1:0] z_reg, at;
    logic [5:0] cnt_reg;
    logic       busy_reg, vec_reg, done_reg, ccw;

    always_comb
    begin
        xs  = x_reg >>> cnt_reg;
        ys  = y_reg >>> cnt_reg;
        at  = sai_pkg::ZW'(sai_pkg::atan_bau(cnt_reg[4:0]));
        // vectoring drives y to zero, rotation drives z to zero
        ccw = vec_reg ? !(y_reg > 0) : !z_reg[sai_pkg::ZW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            vec_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                vec_reg  <= cmd.vec;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(CORDIC_ITERS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg <= x_in;
            y_reg <= y_in;
            z_reg <= z_in;
        end
        else if (busy_reg)
        begin
            if (ccw)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ===== rtl/sai_isqrt.sv =====
module sai_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [62:0] m_in,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] m_reg, res_reg, bit_reg, trial;
    logic [4:0]  cnt_reg;
    logic        busy_reg, done_reg;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one result bit per cycle, restoring form
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            m_reg   <= {1'b0, m_in};
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (m_reg >= trial)
            begin
                m_reg   <= m_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

// ===== rtl/sai_div.sv =====
module sai_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [61:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [31:0] quo
);

    logic [31:0] rem_reg, nlow_reg, q_reg;
    logic [32:0] trial;
    logic        ge, sat_reg, busy_reg, done_reg;
    logic [4:0]  cnt_reg;

    assign trial = {rem_reg, nlow_reg[31]};
    assign ge    = trial >= {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // quotient of 2^32 or more saturates anyway
            sat_reg  <= {2'b00, num[61:32]} >= den;
            rem_reg  <= {2'b00, num[61:32]};
            nlow_reg <= num[31:0];
            q_reg    <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? 32'(trial - {1'b0, den}) : trial[31:0];
            nlow_reg <= {nlow_reg[30:0], 1'b0};
            q_reg    <= {q_reg[30:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = (sat_reg || q_reg > sai_pkg::HALF_TURN) ? sai_pkg::HALF_TURN : q_reg;

endmodule

// ===== rtl/semicircle_arc_interpolator.sv =====
// semicircle arc interpolator, q16.16 coordinates, binary angle units
// load transfer: multiplier, isqrt, cordic vectoring, multiplier, divider, in that order
// point transfer: cordic rotation, then the multiplier for cosine and sine
// one transfer in work at a time; the result register frees the input side early
// rst_n is asynchronous, active low: phase goes idle, move state but step_reg clears to zero
module semicircle_arc_interpolator #(
    parameter int MAX_ARC_POINTS = sai_pkg::DEF_MAX_ARC_POINTS,
    parameter int CORDIC_ITERS   = sai_pkg::DEF_CORDIC_ITERS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // start_x[31:0], start_y[63:32], end_x[95:64], end_y[127:96], step_length[158:128]
    input  logic [159:0] s_axis_tdata,
    // action: 0 load move, 1 next point
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pos_x[33:0], pos_y[67:34], vel_x[101:68], vel_y[135:102]
    output logic [135:0] m_axis_tdata,
    // last point of the move
    output logic         m_axis_tlast
);

    localparam int CW = $clog2(MAX_ARC_POINTS + 1);
    localparam int XW = sai_pkg::XW;
    localparam int ZW = sai_pkg::ZW;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MULA  = 4'd1;
    localparam logic [3:0] S_MULB  = 4'd2;
    localparam logic [3:0] S_SQRT  = 4'd3;
    localparam logic [3:0] S_SQRTW = 4'd4;
    localparam logic [3:0] S_VEC   = 4'd5;
    localparam logic [3:0] S_VECW  = 4'd6;
    localparam logic [3:0] S_DIVM  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_DIVW  = 4'd9;
    localparam logic [3:0] S_ROT   = 4'd10;
    localparam logic [3:0] S_ROTW  = 4'd11;
    localparam logic [3:0] S_MULC  = 4'd12;
    localparam logic [3:0] S_MULS  = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    // move phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ARC   = 2'd1;
    localparam logic [1:0] PH_FINAL = 2'd2;

    logic [3:0] state_reg;
    logic [1:0] phase_reg;

    // move state
    logic signed [31:0] cx_reg, cy_reg, tx_reg, ty_reg;
    logic [31:0]        radius_reg, cur_reg, end_reg, astep_reg;
    logic [32:0]        swept_reg;
    logic [CW-1:0]      count_reg;
    logic [30:0]        step_reg;

    // load scratch
    logic signed [32:0] vx_reg, vy_reg;
    logic [32:0]        ux_reg, uy_reg;
    logic [63:0]        acc_reg;

    // point scratch
    logic [31:0]        ang_reg;
    logic               last_reg, neg_reg;
    logic signed [32:0] c_reg, s_reg;
    logic signed [33:0] sc_reg;

    // shared multiplier with registered product
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_reg;

    // result register
    logic         out_valid_reg;
    logic [135:0] out_data_reg;
    logic         out_last_reg;

    // input fields
    logic               action;
    logic signed [31:0] sx, sy, ex, ey;
    logic [30:0]        step_in;
    logic signed [32:0] dx, dy, sum_x, sum_y, cx_new, cy_new;

    assign action  = s_axis_tuser[0];
    assign sx      = s_axis_tdata[31:0];
    assign sy      = s_axis_tdata[63:32];
    assign ex      = s_axis_tdata[95:64];
    assign ey      = s_axis_tdata[127:96];
    assign step_in = s_axis_tdata[158:128];

    assign dx     = 33'(ex) - 33'(sx);
    assign dy     = 33'(ey) - 33'(sy);
    assign sum_x  = 33'(sx) + 33'(ex);
    assign sum_y  = 33'(sy) + 33'(ey);
    assign cx_new = sum_x >>> 1;
    assign cy_new = sum_y >>> 1;

    assign s_axis_tready = (state_reg == S_IDLE);

    // shared cordic
    sai_pkg::cordic_cmd_t cmd;
    logic signed [XW-1:0] cx_in, cy_in, cx_out, cy_out;
    logic signed [ZW-1:0] cz_in, cz_out;
    logic                 cordic_done;
    logic [31:0]          rot_a;
    logic                 rot_neg;

    always_comb
    begin
        rot_neg = (ang_reg[31:30] == 2'd1) || (ang_reg[31:30] == 2'd2);
        rot_a   = rot_neg ? ang_reg - sai_pkg::HALF_TURN : ang_reg;
        cmd.start = (state_reg == S_ROT) || (state_reg == S_VEC);
        cmd.vec   = (state_reg == S_VEC);
        if (state_reg == S_VEC)
        begin
            // fold the left half plane over before vectoring
            cx_in = vx_reg[32] ? -XW'(vx_reg) : XW'(vx_reg);
            cy_in = vx_reg[32] ? -XW'(vy_reg) : XW'(vy_reg);
            cz_in = vx_reg[32] ? ZW'(sai_pkg::HALF_TURN) : '0;
        end
        else
        begin
            cx_in = sai_pkg::CORDIC_GAIN_INV;
            cy_in = '0;
            cz_in = ZW'($signed(rot_a));
        end
    end

    sai_cordic #(
        .CORDIC_ITERS(CORDIC_ITERS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .x_in  (cx_in),
        .y_in  (cy_in),
        .z_in  (cz_in),
        .done  (cordic_done),
        .x_out (cx_out),
        .y_out (cy_out),
        .z_out (cz_out)
    );

    // radius = isqrt(a*(a+p) + b*(b+q))
    logic        sqrt_done;
    logic [31:0] sqrt_root;

    sai_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_SQRT),
        .m_in  (63'(acc_reg + 64'(mul_reg))),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // angle step = step * turn_per_rad / radius
    logic        div_done;
    logic [31:0] div_quo;

    sai_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_DIV),
        .num   (mul_reg[61:0]),
        .den   (radius_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        case (state_reg)
            S_MULA:
            begin
                mul_a = 33'(ux_reg[32:1]);
                mul_b = 33'(ux_reg[32:1]) + 33'(ux_reg[0]);
            end
            S_MULB:
            begin
                mul_a = 33'(uy_reg[32:1]);
                mul_b = 33'(uy_reg[32:1]) + 33'(uy_reg[0]);
            end
            S_DIVM:
            begin
                mul_a = 33'(step_reg);
                mul_b = 33'(sai_pkg::TURN_PER_RAD);
            end
            S_MULC:
            begin
                mul_a = 33'(radius_reg);
                mul_b = c_reg;
            end
            default:
            begin
                mul_a = 33'(radius_reg);
                mul_b = s_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= 66'(mul_a) * 66'(mul_b);
    end

    // scale by radius, rounded half up out of q2.30
    logic signed [65:0] sc_round, ss_round;
    logic signed [33:0] sc_now, ss_now, pos_x, pos_y;

    assign sc_round = (mul_reg + 66'sd536870912) >>> 30;
    assign ss_round = sc_round;
    assign sc_now   = sc_round[33:0];
    assign ss_now   = ss_round[33:0];
    assign pos_x    = last_reg ? 34'(tx_reg) : 34'(cx_reg) + sc_reg;
    assign pos_y    = last_reg ? 34'(ty_reg) : 34'(cy_reg) + ss_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            cx_reg        <= '0;
            cy_reg        <= '0;
            tx_reg        <= '0;
            ty_reg        <= '0;
            radius_reg    <= '0;
            cur_reg       <= '0;
            end_reg       <= '0;
            astep_reg     <= '0;
            swept_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // the output state loads the result register itself
            if (m_axis_tready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        if (!action)
                        begin
                            // load restarts the move in any phase
                            tx_reg    <= ex;
                            ty_reg    <= ey;
                            swept_reg <= '0;
                            count_reg <= '0;
                            if (dx == '0 && dy == '0)
                            begin
                                cx_reg     <= sx;
                                cy_reg     <= sy;
                                radius_reg <= '0;
                                astep_reg  <= '0;
                                cur_reg    <= '0;
                                end_reg    <= '0;
                                phase_reg  <= PH_FINAL;
                            end
                            else
                            begin
                                cx_reg    <= cx_new[31:0];
                                cy_reg    <= cy_new[31:0];
                                state_reg <= S_MULA;
                            end
                        end
                        else if (phase_reg == PH_ARC && swept_reg < 33'(sai_pkg::HALF_TURN)
                                 && count_reg < CW'(MAX_ARC_POINTS))
                        begin
                            cur_reg   <= cur_reg + astep_reg;
                            swept_reg <= swept_reg + 33'(astep_reg);
                            count_reg <= count_reg + CW'(1);
                            state_reg <= S_ROT;
                        end
                        else if (phase_reg == PH_ARC || phase_reg == PH_FINAL)
                        begin
                            phase_reg <= PH_IDLE;
                            state_reg <= S_ROT;
                        end
                    end
                end
                S_MULA:  state_reg <= S_MULB;
                S_MULB:  state_reg <= S_SQRT;
                S_SQRT:  state_reg <= S_SQRTW;
                S_SQRTW:
                begin
                    if (sqrt_done)
                    begin
                        radius_reg <= sqrt_root;
                        state_reg  <= S_VEC;
                    end
                end
                S_VEC:   state_reg <= S_VECW;
                S_VECW:
                begin
                    if (cordic_done)
                    begin
                        cur_reg   <= cz_out[31:0];
                        end_reg   <= cz_out[31:0] + sai_pkg::HALF_TURN;
                        state_reg <= S_DIVM;
                    end
                end
                S_DIVM:
                begin
                    if (radius_reg == '0)
                    begin
                        // tiny radius: one center point, then the end point
                        astep_reg <= sai_pkg::HALF_TURN;
                        phase_reg <= PH_ARC;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:   state_reg <= S_DIVW;
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        astep_reg <= div_quo;
                        phase_reg <= PH_ARC;
                        state_reg <= S_IDLE;
                    end
                end
                S_ROT:   state_reg <= S_ROTW;
                S_ROTW:
                begin
                    if (cordic_done)
                    begin
                        state_reg <= S_MULC;
                    end
                end
                S_MULC:  state_reg <= S_MULS;
                S_MULS:  state_reg <= S_OUT;
                S_OUT:
                begin
                    // wait until the result register is free
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // payload scratch, no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    step_reg <= step_in;
                    ux_reg   <= dx[32] ? 33'(-dx) : 33'(dx);
                    uy_reg   <= dy[32] ? 33'(-dy) : 33'(dy);
                    vx_reg   <= 33'(sx) - cx_new;
                    vy_reg   <= 33'(sy) - cy_new;
                    if (phase_reg == PH_ARC && swept_reg < 33'(sai_pkg::HALF_TURN)
                        && count_reg < CW'(MAX_ARC_POINTS))
                    begin
                        ang_reg  <= cur_reg;
                        last_reg <= 1'b0;
                    end
                    else
                    begin
                        ang_reg  <= end_reg;
                        last_reg <= 1'b1;
                    end
                end
            end
            S_MULB:
            begin
                acc_reg <= 64'(mul_reg);
            end
            S_ROT:
            begin
                neg_reg <= rot_neg;
            end
            S_ROTW:
            begin
                c_reg <= neg_reg ? -cx_out[32:0] : cx_out[32:0];
                s_reg <= neg_reg ? -cy_out[32:0] : cy_out[32:0];
            end
            S_MULS:
            begin
                sc_reg <= sc_now;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_reg <= {sc_reg, 34'(-ss_now), pos_y, pos_x};
                    out_last_reg <= last_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== tb/sv/semicircle_arc_interpolator_test.sv =====
`timescale 1ns / 100ps

module semicircle_arc_interpolator_test;

    typedef enum bit {ACT_LOAD = 1'b0, ACT_NEXT = 1'b1} action_e;
    typedef enum bit [1:0] {PH_IDLE = 2'd0, PH_ARC = 2'd1, PH_FINAL = 2'd2} phase_e;

    localparam int MAX_POINTS  = 100001;
    localparam int ITERS       = 24;
    localparam longint HALF    = 64'h8000_0000;
    localparam longint GAIN    = 652032874;
    localparam longint RAD_BAU = 683565276;
    localparam int LIMIT       = 3000000;
    localparam int TARGET      = 1550;

    typedef struct {
        action_e     act;
        logic [31:0] sx, sy, ex, ey;
        logic [30:0] step;
        bit          drain;      // wait until every expected point is out
    } move_item_t;

    typedef struct {
        logic [33:0] px, py, vx, vy;
        logic        last;
    } arc_point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [159:0] s_axis_tdata = '0;
    logic [0:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic m_axis_tlast;

    semicircle_arc_interpolator dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // stimulus and expectation stores
    move_item_t pending_moves[$];
    move_item_t cur_item;
    arc_point_t expected_points[$];
    int n_errors = 0, n_points = 0, n_lasts = 0, n_loads = 0, n_sent = 0;
    int cycle = 0;
    int hold_left = 0;
    bit calm;

    // predictor state
    longint cen_x, cen_y, tgt_x, tgt_y;
    longint unsigned rad, ang_step, swept;
    logic [31:0] cur_ang, end_ang;
    int pt_count;
    phase_e ph;

    longint atan_tab[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0};

    function automatic longint unsigned int_sqrt(longint unsigned m);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > m)
            b >>= 2;
        while (b != 0)
        begin
            if (m >= res + b)
            begin
                m -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // cordic vectoring: angle of (x, y) in binary angle units
    function automatic logic [31:0] angle_of(longint x, longint y);
        logic [31:0] z;
        longint xs, ys;
        z = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = HALF[31:0];
        end
        for (int i = 0; i < ITERS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys; y -= xs; z += atan_tab[i][31:0];
            end
            else
            begin
                x -= ys; y += xs; z -= atan_tab[i][31:0];
            end
        end
        return z;
    endfunction

    // cordic rotation: q2.30 cosine and sine
    task automatic rotate(input logic [31:0] a, output longint c, output longint s);
        longint x, y, z, xs, ys;
        bit neg;
        x = GAIN;
        y = 0;
        neg = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (neg)
            a = a - HALF[31:0];
        z = longint'(signed'(a));
        for (int i = 0; i < ITERS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= atan_tab[i];
            end
            else
            begin
                x += ys; y -= xs; z += atan_tab[i];
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endtask

    function automatic longint by_radius(longint u);
        return (longint'(rad) * u + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // advance the arc model by one accepted transfer, queue any point it yields
    task automatic predict_arc(input move_item_t it);
        longint sx, sy, ex, ey, dx, dy, c, s;
        longint unsigned ux, uy, a, b;
        arc_point_t pt;
        if (it.act == ACT_LOAD)
        begin
            n_loads++;
            sx = longint'(signed'(it.sx)); sy = longint'(signed'(it.sy));
            ex = longint'(signed'(it.ex)); ey = longint'(signed'(it.ey));
            dx = ex - sx; dy = ey - sy;
            tgt_x = ex; tgt_y = ey;
            swept = 0; pt_count = 0;
            if (dx == 0 && dy == 0)
            begin
                cen_x = sx; cen_y = sy; rad = 0; ang_step = 0;
                cur_ang = 0; end_ang = 0; ph = PH_FINAL;
                return;
            end
            ux = dx < 0 ? -dx : dx;
            uy = dy < 0 ? -dy : dy;
            a = ux >> 1; b = uy >> 1;
            cen_x = (sx + ex) >>> 1;
            cen_y = (sy + ey) >>> 1;
            rad = int_sqrt(a * a + a * ux[0] + b * b + b * uy[0]);
            cur_ang = angle_of(sx - cen_x, sy - cen_y);
            end_ang = cur_ang + HALF[31:0];
            if (rad == 0)
                ang_step = HALF;
            else
            begin
                ang_step = longint'(it.step) * RAD_BAU / rad;
                if (ang_step > HALF)
                    ang_step = HALF;
            end
            ph = PH_ARC;
            return;
        end
        if (ph == PH_ARC && swept < HALF && pt_count < MAX_POINTS)
        begin
            rotate(cur_ang, c, s);
            pt.px = 34'(cen_x + by_radius(c));
            pt.py = 34'(cen_y + by_radius(s));
            pt.last = 1'b0;
            cur_ang += ang_step[31:0];
            swept += ang_step;
            pt_count++;
        end
        else if (ph == PH_ARC || ph == PH_FINAL)
        begin
            rotate(end_ang, c, s);
            pt.px = 34'(tgt_x);
            pt.py = 34'(tgt_y);
            pt.last = 1'b1;
            ph = PH_IDLE;
        end
        else
            return;
        pt.vx = 34'(-by_radius(s));
        pt.vy = 34'(by_radius(c));
        expected_points = {expected_points, pt};
    endtask

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle >= LIMIT)
        begin
            $display("timeout after %0d cycles", cycle);
            $display("semicircle_arc_interpolator_test failed");
            $finish;
        end
    end

    // no idling on either side in this window
    assign calm = (cycle > 6000) && (cycle < 12000);

    // long receiver hold-off, counted here, while the sender keeps going
    always @(posedge clk)
    begin
        if (cycle == 20000)
            hold_left <= 600;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // sender: a transfer completes on valid and ready, the model sees it then
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_arc(cur_item);
                n_sent++;
            end
            if (s_axis_tvalid && !s_axis_tready)
                ;   // hold the offered transfer
            else if (pending_moves.size() > 0
                     && (calm || $urandom_range(99) >= 29)
                     && !(pending_moves[0].drain && expected_points.size() != 0))
            begin
                cur_item = pending_moves.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= cur_item.act;
                s_axis_tdata <= {1'b0, cur_item.step, cur_item.ey, cur_item.ex,
                                 cur_item.sy, cur_item.sx};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver: compare each point with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        arc_point_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("point with nothing expected: %h", m_axis_tdata);
                    n_errors++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    n_points++;
                    if (want.last)
                        n_lasts++;
                    if (m_axis_tdata[33:0] !== want.px)
                    begin
                        $error("pos_x expected %h got %h", want.px, m_axis_tdata[33:0]);
                        n_errors++;
                    end
                    if (m_axis_tdata[67:34] !== want.py)
                    begin
                        $error("pos_y expected %h got %h", want.py, m_axis_tdata[67:34]);
                        n_errors++;
                    end
                    if (m_axis_tdata[101:68] !== want.vx)
                    begin
                        $error("vel_x expected %h got %h", want.vx, m_axis_tdata[101:68]);
                        n_errors++;
                    end
                    if (m_axis_tdata[135:102] !== want.vy)
                    begin
                        $error("vel_y expected %h got %h", want.vy, m_axis_tdata[135:102]);
                        n_errors++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last expected %b got %b", want.last, m_axis_tlast);
                        n_errors++;
                    end
                end
            end
            m_axis_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= 29);
        end
    end

    int queued = 0;

    task automatic add_item(action_e act, logic [31:0] sx, logic [31:0] sy,
                            logic [31:0] ex, logic [31:0] ey, logic [30:0] step,
                            bit drain = 0);
        move_item_t it;
        it.act = act; it.sx = sx; it.sy = sy; it.ex = ex; it.ey = ey;
        it.step = step; it.drain = drain;
        pending_moves = {pending_moves, it};
        queued++;
    endtask

    task automatic add_nexts(int n);
        for (int i = 0; i < n; i++)
            add_item(ACT_NEXT, $urandom, $urandom, $urandom, $urandom, 31'($urandom));
    endtask

    // a load with a step chosen for about k points, then the next requests
    task automatic add_move(int k, bit wide);
        logic [31:0] sx, sy, ex, ey;
        real r, st;
        logic [30:0] step;
        int extra;
        if (wide)
        begin
            sx = $urandom; sy = $urandom; ex = $urandom; ey = $urandom;
        end
        else
        begin
            sx = 32'($signed($urandom_range(2097151)) - 1048576);
            sy = 32'($signed($urandom_range(2097151)) - 1048576);
            ex = sx + 32'($signed($urandom_range(65535)) - 32768);
            ey = sy + 32'($signed($urandom_range(65535)) - 32768);
        end
        r = $sqrt((real'($signed(ex)) - real'($signed(sx))) ** 2
                + (real'($signed(ey)) - real'($signed(sy))) ** 2) / 2.0;
        st = r * 3.14159265 / k;
        if ($urandom_range(9) == 0)
            step = 31'($urandom);
        else if (st < 1.0)
            step = 31'd1;
        else if (st > 2147483647.0)
            step = 31'h7fff_ffff;
        else
            step = 31'($rtoi(st));
        add_item(ACT_LOAD, sx, sy, ex, ey, step);
        extra = $urandom_range(4);
        // now and then a move is cut short by the next load
        if ($urandom_range(9) == 0)
            add_nexts($urandom_range(k));
        else
            add_nexts(k + 2 + extra);
    endtask

    initial
    begin
        // next request while idle
        add_item(ACT_NEXT, 0, 0, 0, 0, 0);
        // zero-length move, then an idle request
        add_item(ACT_LOAD, 32'h0001_0000, 32'hffff_0000, 32'h0001_0000, 32'hffff_0000, 31'd5);
        add_nexts(2);
        // tiny radius: neighboring points
        add_item(ACT_LOAD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0001, 32'h7fff_ffff, 31'd1);
        add_nexts(3);
        // corner to corner, largest step
        add_item(ACT_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                 31'h7fff_ffff);
        add_nexts(3);
        // reverse, moderate step
        add_item(ACT_LOAD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                 31'h4000_0000);
        add_nexts(5);
        // load in the middle of an arc restarts it
        add_item(ACT_LOAD, 32'h0, 32'h0, 32'h0004_0000, 32'h0, 31'h0000_8000);
        add_nexts(3);
        add_item(ACT_LOAD, 32'h0, 32'h0, 32'h0, 32'h0002_0000, 31'h0000_4000, 1);
        add_nexts(14);

        while (queued < TARGET)
        begin
            if ($urandom_range(19) == 0)
                add_nexts($urandom_range(3));   // noise
            else
                add_move($urandom_range(1, 25), $urandom_range(1) == 1);
            // once mid run the sender waits for the output to drain
            if (queued > 700 && queued < 740)
                pending_moves[pending_moves.size() - 1].drain = 1;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_moves.size() == 0 && !s_axis_tvalid);
        wait (expected_points.size() == 0);
        repeat (300) @(posedge clk);

        $display("%0d transfers sent, %0d loads, %0d points checked, %0d moves ended",
                 n_sent, n_loads, n_points, n_lasts);
        if (n_errors == 0 && expected_points.size() == 0)
            $display("semicircle_arc_interpolator_test passed");
        else
            $display("semicircle_arc_interpolator_test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sai_pkg.sv
rtl/sai_cordic.sv
rtl/sai_isqrt.sv
rtl/sai_div.sv
rtl/semicircle_arc_interpolator.sv
tb/sv/semicircle_arc_interpolator_test.sv
